[rtl/deque_with_search_defines.svh]
// Assertion macros used by deque_with_search, which checks its own logic.
`ifndef DEQUE_WITH_SEARCH_DEFINES_SVH
`define DEQUE_WITH_SEARCH_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DWS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define DWS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/dws_pkg.sv]
`timescale 1ns / 1ps

package dws_pkg;

    typedef logic [2:0] op_t;
    typedef logic [1:0] status_t;
    typedef logic [5:0] fill_t;

    localparam op_t OP_PUSH_FRONT = 3'd0;
    localparam op_t OP_PUSH_BACK  = 3'd1;
    localparam op_t OP_POP_FRONT  = 3'd2;
    localparam op_t OP_POP_BACK   = 3'd3;
    localparam op_t OP_SEARCH     = 3'd4;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

    localparam int FILL_W = 6;

endpackage

[rtl/dws_ram.sv]
`timescale 1ns / 1ps

module dws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                          clk,
    input  logic                                          wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
    input  logic [WIDTH-1:0]                              wr_data,
    input  logic                                          rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
    output logic [WIDTH-1:0]                              rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/deque_with_search.sv]
`timescale 1ns / 1ps
`include "deque_with_search_defines.svh"

// Bounded double-ended queue of 32-bit values with a linear search.
// Input channel: an item (operation, value) is taken at a rising edge where
// start is high and busy is low. Output channel: each item yields exactly one
// result, shown for one cycle while done is high, carrying status, found,
// removed_value and fill_level.
// Inserts, unused codes, removals from an empty store and searches of an
// empty store answer in the cycle after the item is taken, and busy stays low,
// so such items may follow every cycle.
// A removal reads the entry memory into its read register when the item is taken;
// state S_POP then registers that value as the result, with busy high for one cycle.
// A search reads one held entry per cycle through the single read port of the
// entry memory and stops at the first match or after the last held entry;
// a full store of DEPTH entries is read in full when nothing matches.
// Reset clears the front index and the entry count, leaving the store empty;
// the memory itself needs no clearing pass because only held entries are read.
// The receiver cannot stall: every result must be taken in its done cycle.
module deque_with_search #(
    parameter int DEPTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  dws_pkg::op_t      operation,
    input  logic signed [31:0] value,
    output logic              busy,
    output logic              done,
    output dws_pkg::status_t  status,
    output logic              found,
    output logic signed [31:0] removed_value,
    output dws_pkg::fill_t    fill_level
);

    import dws_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] issued_reg, issued_next;
    logic [31:0]   value_reg, value_next;
    logic          done_reg, done_next;
    status_t       status_reg, status_next;
    logic          found_reg, found_next;
    logic [31:0]   removed_reg, removed_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [31:0]   rd_data;
    logic [CW+FILL_W-1:0] fill_ext;

    function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] a);
        return (a == LAST_IDX) ? '0 : AW'(a + 1'b1);
    endfunction

    function automatic logic [AW-1:0] dec_idx(input logic [AW-1:0] a);
        return (a == '0) ? LAST_IDX : AW'(a - 1'b1);
    endfunction

    function automatic logic [AW-1:0] add_idx(input logic [AW-1:0] a,
                                              input logic [CW-1:0] b);
        logic [CW:0] s;
        s = (CW+1)'(a) + (CW+1)'(b);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    dws_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        ptr_next     = ptr_reg;
        issued_next  = issued_reg;
        value_next   = value_reg;
        done_next    = 1'b0;
        status_next  = ST_OK;
        found_next   = 1'b0;
        removed_next = '0;
        wr_en        = 1'b0;
        wr_addr      = front_reg;
        rd_en        = 1'b0;
        rd_addr      = front_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (operation)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            done_next = 1'b1;
                            if (count_reg == FULL_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = CW'(count_reg + 1'b1);
                                if (operation == OP_PUSH_FRONT)
                                begin
                                    wr_addr    = dec_idx(front_reg);
                                    front_next = dec_idx(front_reg);
                                end
                                else
                                begin
                                    wr_addr = add_idx(front_reg, count_reg);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                done_next   = 1'b1;
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                count_next = CW'(count_reg - 1'b1);
                                state_next = S_POP;
                                if (operation == OP_POP_FRONT)
                                begin
                                    rd_addr    = front_reg;
                                    front_next = inc_idx(front_reg);
                                end
                                else
                                begin
                                    rd_addr = add_idx(front_reg, CW'(count_reg - 1'b1));
                                end
                            end
                        end
                        OP_SEARCH:
                        begin
                            value_next = value;
                            if (count_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = front_reg;
                                ptr_next    = inc_idx(front_reg);
                                issued_next = CW'(1);
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_POP:
            begin
                done_next    = 1'b1;
                removed_next = rd_data;
                state_next   = S_IDLE;
            end
            S_SCAN:
            begin
                if (rd_data == value_reg)
                begin
                    done_next  = 1'b1;
                    found_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (issued_reg == count_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rd_en       = 1'b1;
                    rd_addr     = ptr_reg;
                    ptr_next    = inc_idx(ptr_reg);
                    issued_next = CW'(issued_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            ptr_reg    <= '0;
            issued_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            ptr_reg    <= ptr_next;
            issued_reg <= issued_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        status_reg  <= status_next;
        found_reg   <= found_next;
        removed_reg <= removed_next;
    end

    assign fill_ext      = {{FILL_W{1'b0}}, count_reg};
    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = status_reg;
    assign found         = found_reg;
    assign removed_value = removed_reg;
    assign fill_level    = fill_ext[FILL_W-1:0];

    `DWS_ASSERT_NOW(a_count_range, 1'b1, count_reg <= FULL_CNT, "entry count beyond depth")
    `DWS_ASSERT_NOW(a_done_idle, done, !busy, "result shown while still busy")
    `DWS_ASSERT_NOW(a_full_status, done && (status == ST_FULL), count_reg == FULL_CNT,
        "full status with room left")
    `DWS_ASSERT_NEXT(a_push_done,
        start && !busy && ((operation == OP_PUSH_FRONT) || (operation == OP_PUSH_BACK)),
        done && !busy, "insert did not answer in one cycle")

endmodule
